// ===== sv/fpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the FIFO page replacement unit.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int CFG_W   = 5;   // frame_count register width
  localparam int SLOT_W  = 4;   // reported slot width
  localparam int FAULT_W = 32;  // fault counter width

  localparam logic [CFG_W-1:0] FC_RESET = 5'd16;

  // controller -> datapath
  typedef struct packed {
    logic load_in;   // latch the incoming page
    logic scan;      // scan phase, compare results are live
    logic rd_scan;   // read frame at the scan index
    logic rd_last;   // this scan read is the last active frame
    logic rd_ptr;    // read the frame under the insert pointer
    logic write;     // fault update: replace frame, bump pointer and counter
    logic load_out;  // move result into the output register
  } fpr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;       // compare stage found the page
    logic miss;      // last compare finished without a match
    logic out_free;  // output register can take a result this cycle
  } fpr_stat_t;

endpackage

// ===== sv/fpr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_ctrl
// Sequencer: walks the scan index over the active frames, then on a miss runs
// the fault update, and hands the result to the output register.
// ----------------------------------------------------------------------------
module fpr_ctrl #(
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IDX_W-1:0]  last_idx,
  input  fpr_pkg::fpr_stat_t st,
  output fpr_pkg::fpr_cmd_t  cmd,
  output logic [IDX_W-1:0]  scan_idx
);
  import fpr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVICT,
    S_WRITE,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             issued_all_r, issued_all_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign scan_idx = scan_idx_r;

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    issued_all_nxt = issued_all_r;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in    = 1'b1;
          scan_idx_nxt   = '0;
          issued_all_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan    = 1'b1;
        cmd.rd_scan = !issued_all_r;
        cmd.rd_last = (scan_idx_r == last_idx);
        if (cmd.rd_scan) begin
          if (cmd.rd_last) issued_all_nxt = 1'b1;
          else             scan_idx_nxt   = scan_idx_r + 1'b1;
        end
        if (st.hit)       state_nxt = S_DONE;
        else if (st.miss) state_nxt = S_EVICT;
      end
      S_EVICT: begin
        cmd.rd_ptr = 1'b1;
        state_nxt  = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_idx_r   <= '0;
      issued_all_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      issued_all_r <= issued_all_nxt;
    end
  end

endmodule

// ===== sv/fpr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_datapath
// Frame page memory, valid bits, insert pointer, fault counter, compare
// stage, result and output registers, frame_count register.
// ----------------------------------------------------------------------------
module fpr_datapath #(
  parameter int FRAME_SLOTS = 16,
  parameter int PAGE_BITS   = 20,
  parameter int IDX_W       = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fpr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [PAGE_BITS-1:0]          in_page_number,
  input  fpr_pkg::fpr_cmd_t             cmd,
  input  logic [IDX_W-1:0]              scan_idx,
  output fpr_pkg::fpr_stat_t            st,
  output logic [IDX_W-1:0]              last_idx,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [fpr_pkg::SLOT_W-1:0]    out_slot,
  output logic                          out_evicted_valid,
  output logic [PAGE_BITS-1:0]          out_evicted_page,
  output logic [fpr_pkg::FAULT_W-1:0]   out_fault_total
);
  import fpr_pkg::*;

  logic [PAGE_BITS-1:0]   mem [FRAME_SLOTS];

  logic [CFG_W-1:0]       frame_count_r;
  logic [FRAME_SLOTS-1:0] valid_r;
  logic [IDX_W-1:0]       ptr_r;
  logic [FAULT_W-1:0]     fault_r;
  logic [PAGE_BITS-1:0]   page_r;

  logic [PAGE_BITS-1:0]   rd_data_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   cmp_pend_r;
  logic                   cmp_last_r;

  logic                   res_hit_r;
  logic [SLOT_W-1:0]      res_slot_r;
  logic                   res_ev_valid_r;
  logic [PAGE_BITS-1:0]   res_ev_page_r;
  logic [FAULT_W-1:0]     res_fault_r;

  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic                   out_ev_valid_r;
  logic [PAGE_BITS-1:0]   out_ev_page_r;
  logic [FAULT_W-1:0]     out_fault_r;

  logic [IDX_W-1:0]       ptr_eff;
  logic [IDX_W-1:0]       ptr_adv;
  logic [IDX_W-1:0]       rd_addr;
  logic [FAULT_W-1:0]     fault_inc;
  logic                   cmp_hit;

  // active frames: zero acts as one, above the built count saturates
  always_comb begin
    if (frame_count_r == '0)
      last_idx = '0;
    else if (32'(frame_count_r) > FRAME_SLOTS)
      last_idx = IDX_W'(FRAME_SLOTS - 1);
    else
      last_idx = IDX_W'(frame_count_r - 1'b1);
  end

  assign ptr_eff   = (ptr_r > last_idx) ? '0 : ptr_r;
  assign ptr_adv   = (ptr_eff == last_idx) ? '0 : ptr_eff + 1'b1;
  assign fault_inc = (fault_r == '1) ? fault_r : fault_r + 1'b1;
  assign rd_addr   = cmd.rd_ptr ? ptr_eff : scan_idx;

  assign cmp_hit     = cmp_pend_r && valid_r[rd_idx_r] && (rd_data_r == page_r);
  assign st.hit      = cmp_hit;
  assign st.miss     = cmp_pend_r && cmp_last_r && !cmp_hit;
  assign st.out_free = !out_valid_r || out_ready;

  // page memory: one read port, one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_scan || cmd.rd_ptr) rd_data_r <= mem[rd_addr];
    if (cmd.write) mem[ptr_eff] <= page_r;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) page_r <= in_page_number;
    rd_idx_r   <= scan_idx;
    cmp_last_r <= cmd.rd_last;
    if (cmd.scan && cmp_hit) begin
      res_hit_r      <= 1'b1;
      res_slot_r     <= SLOT_W'(rd_idx_r);
      res_ev_valid_r <= 1'b0;
      res_ev_page_r  <= '0;
      res_fault_r    <= fault_r;
    end else if (cmd.write) begin
      res_hit_r      <= 1'b0;
      res_slot_r     <= SLOT_W'(ptr_eff);
      res_ev_valid_r <= valid_r[ptr_eff];
      res_ev_page_r  <= valid_r[ptr_eff] ? rd_data_r : '0;
      res_fault_r    <= fault_inc;
    end
    if (cmd.load_out) begin
      out_hit_r      <= res_hit_r;
      out_slot_r     <= res_slot_r;
      out_ev_valid_r <= res_ev_valid_r;
      out_ev_page_r  <= res_ev_page_r;
      out_fault_r    <= res_fault_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FC_RESET;
      valid_r       <= '0;
      ptr_r         <= '0;
      fault_r       <= '0;
      cmp_pend_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      cmp_pend_r <= cmd.rd_scan;
      if (cmd.load_out)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        frame_count_r <= cfg_wdata;
        valid_r       <= '0;
        ptr_r         <= '0;
      end else if (cmd.write) begin
        valid_r[ptr_eff] <= 1'b1;
        ptr_r            <= ptr_adv;
        fault_r          <= fault_inc;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = out_fault_r;

endmodule

// ===== sv/fifo_page_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_replacement
// Page reference unit with round-robin (FIFO) frame replacement.
// The scan reads one frame per cycle from the page memory, which has one read
// port and one write port. One item in flight; the next item is taken in the
// cycle after the result is loaded, even while it waits in the output register.
// Reset (sync, active low): frames empty, pointer and fault count zero,
// frame_count 16. Page memory contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_page_replacement #(
  parameter int FRAME_SLOTS = 16,
  parameter int PAGE_BITS   = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fpr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [PAGE_BITS-1:0]          in_page_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [fpr_pkg::SLOT_W-1:0]    out_slot,
  output logic                          out_evicted_valid,
  output logic [PAGE_BITS-1:0]          out_evicted_page,
  output logic [fpr_pkg::FAULT_W-1:0]   out_fault_total
);
  import fpr_pkg::*;

  localparam int IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

  fpr_cmd_t         cmd;
  fpr_stat_t        st;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] last_idx;

  fpr_ctrl #(
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .last_idx (last_idx),
    .st       (st),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  fpr_datapath #(
    .FRAME_SLOTS(FRAME_SLOTS),
    .PAGE_BITS  (PAGE_BITS),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_page_number    (in_page_number),
    .cmd               (cmd),
    .scan_idx          (scan_idx),
    .st                (st),
    .last_idx          (last_idx),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

  // one item at a time: no second accept right after one
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted_valid))
    else $error("hit result carries an eviction");

  // evicted page is zero when nothing was replaced
  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted_valid) |-> (out_evicted_page == '0))
    else $error("evicted page nonzero without eviction");

  // scan never reports hit and miss together
  a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
    !(st.hit && st.miss))
    else $error("scan reported hit and miss at once");

endmodule

// ===== tb/fpr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_checker
// Watches the page reference and result channels of the FIFO page replacement
// unit. It keeps its own copy of the frame table, the insert pointer, the fault
// counter and frame_count. From these it predicts each result and compares
// every returned item, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module fpr_checker #(
  parameter int FRAME_SLOTS = 16,
  parameter int PAGE_BITS   = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fpr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [PAGE_BITS-1:0]          in_page_number,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_hit,
  input  logic [fpr_pkg::SLOT_W-1:0]    out_slot,
  input  logic                          out_evicted_valid,
  input  logic [PAGE_BITS-1:0]          out_evicted_page,
  input  logic [fpr_pkg::FAULT_W-1:0]   out_fault_total,
  output int                            mismatch_count,
  output int                            lookups_outstanding
);
  import fpr_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_total;
  } lookup_t;

  logic [PAGE_BITS-1:0] resident_page [FRAME_SLOTS];
  logic                 resident      [FRAME_SLOTS];
  int unsigned          next_victim;
  logic [FAULT_W-1:0]   faults_seen;
  logic [CFG_W-1:0]     frames_cfg;
  lookup_t              lookup_q [$];

  // frame_count of zero acts as one frame, anything above the build size clamps
  function automatic int unsigned frames_in_use();
    int unsigned n;
    n = frames_cfg;
    if (n < 1) n = 1;
    if (n > FRAME_SLOTS) n = FRAME_SLOTS;
    return n;
  endfunction

  function automatic lookup_t reference_page(logic [PAGE_BITS-1:0] pg);
    lookup_t     r;
    int unsigned n;
    int unsigned p;
    n = frames_in_use();
    r = '0;
    // lowest matching active frame wins
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      if (i < n && !r.hit && resident[i] && resident_page[i] == pg) begin
        r.hit  = 1'b1;
        r.slot = SLOT_W'(i);
      end
    end
    if (!r.hit) begin
      p = (next_victim >= n) ? 0 : next_victim;
      if (resident[p]) begin
        r.evicted_valid = 1'b1;
        r.evicted_page  = resident_page[p];
      end
      resident_page[p] = pg;
      resident[p]      = 1'b1;
      r.slot           = SLOT_W'(p);
      next_victim      = (p + 1 >= n) ? 0 : p + 1;
      if (faults_seen != '1) faults_seen = faults_seen + 1'b1;
    end
    r.fault_total = faults_seen;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lookup_t want;
    if (!rst_n) begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        resident[i]      = 1'b0;
        resident_page[i] = '0;
      end
      next_victim    = 0;
      faults_seen    = '0;
      frames_cfg     = FC_RESET;
      mismatch_count = 0;
      lookup_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (lookup_q.size() == 0) begin
          $error("result item with no lookup pending (page %0h)", out_evicted_page);
          mismatch_count++;
        end else begin
          want = lookup_q.pop_front();
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_hit);
            mismatch_count++;
          end
          if (out_slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_slot);
            mismatch_count++;
          end
          if (out_evicted_valid !== want.evicted_valid) begin
            $error("evicted_valid: expected %0d, got %0d", want.evicted_valid,
                   out_evicted_valid);
            mismatch_count++;
          end
          if (out_evicted_page !== want.evicted_page) begin
            $error("evicted_page: expected %0h, got %0h", want.evicted_page,
                   out_evicted_page);
            mismatch_count++;
          end
          if (out_fault_total !== want.fault_total) begin
            $error("fault_total: expected %0d, got %0d", want.fault_total,
                   out_fault_total);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) lookup_q.push_back(reference_page(in_page_number));
      // a frame_count write empties the table and rewinds the pointer
      if (cfg_we) begin
        frames_cfg = cfg_wdata;
        for (int i = 0; i < FRAME_SLOTS; i++) resident[i] = 1'b0;
        next_victim = 0;
      end
    end
    lookups_outstanding = lookup_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the FIFO page replacement unit. A short directed run fills and
// wraps the full frame table, then a series of frame_count settings (extremes
// and out-of-range values among them) each run a stream of references drawn
// mostly from a small working set, so that hits, faults and evictions mix.
// Both channels stall at random. fpr_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import fpr_pkg::*;

  localparam int FRAME_SLOTS   = 16;
  localparam int PAGE_BITS     = 20;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 135;
  localparam int POOL_DEPTH    = 24;
  localparam int WATCHDOG      = 3000;
  localparam logic [PAGE_BITS-1:0] PAGE_MAX = '1;

  logic                   clk;
  logic                   rst_n          = 1'b0;
  logic                   cfg_we         = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata      = '0;
  logic                   in_valid       = 1'b0;
  logic                   in_ready;
  logic [PAGE_BITS-1:0]   in_page_number = '0;
  logic                   out_valid;
  logic                   out_ready      = 1'b0;
  logic                   out_hit;
  logic [SLOT_W-1:0]      out_slot;
  logic                   out_evicted_valid;
  logic [PAGE_BITS-1:0]   out_evicted_page;
  logic [FAULT_W-1:0]     out_fault_total;
  int                     bad_results;
  int                     lookups_left;
  int                     idle_cycles    = 0;

  fifo_page_replacement #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .PAGE_BITS   (PAGE_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

  fpr_checker #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .PAGE_BITS   (PAGE_BITS)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_page_number      (in_page_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_slot            (out_slot),
    .out_evicted_valid   (out_evicted_valid),
    .out_evicted_page    (out_evicted_page),
    .out_fault_total     (out_fault_total),
    .mismatch_count      (bad_results),
    .lookups_outstanding (lookups_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure: short stalls, a few long ones, calm stretches
  initial begin : sink_stall
    int stall_len;
    int calm_left;
    stall_len = 0;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        stall_len--;
      end else begin
        out_ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 99) < 3) begin
          calm_left = $urandom_range(50, 300);
        end else if ($urandom_range(0, 99) < 30) begin
          stall_len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_page(input logic [PAGE_BITS-1:0] pg);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else if (roll < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_page_number <= pg;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // lower valid and let every outstanding result drain
  task automatic drain_lookups();
    in_valid <= 1'b0;
    @(negedge clk);
    while (lookups_left != 0) @(negedge clk);
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] fc);
    drain_lookups();
    repeat (3) @(negedge clk);
    cfg_wdata <= fc;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PAGE_BITS-1:0] page_pool [POOL_DEPTH];
    logic [PAGE_BITS-1:0] pg;
    logic [CFG_W-1:0]     fc;
    int                   active;
    int                   pool_size;
    int                   roll;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting of 16 frames: extreme pages, hits, fill, hit in the last
    // frame, then wrap-around evictions
    for (int k = 0; k < 22; k++) begin
      case (k)
        0, 2:    pg = '0;
        1, 3:    pg = PAGE_MAX;
        18:      pg = 20'd14;
        19:      pg = 20'h55555;
        20:      pg = '0;
        21:      pg = PAGE_MAX;
        default: pg = PAGE_BITS'(k - 3);
      endcase
      send_page(pg);
    end

    for (int k = 0; k < POOL_DEPTH; k++)
      page_pool[k] = PAGE_BITS'($urandom_range(0, PAGE_MAX));

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       fc = 5'd1;
        1:       fc = 5'd0;
        2:       fc = 5'd31;
        3:       fc = 5'd17;
        4:       fc = 5'd3;
        5:       fc = 5'd16;
        6:       fc = 5'd8;
        7:       fc = 5'd2;
        8:       fc = 5'd15;
        9:       fc = 5'd5;
        default: fc = CFG_W'($urandom_range(0, 31));
      endcase
      write_frame_count(fc);
      active = (fc == 0) ? 1 : (fc > FRAME_SLOTS) ? FRAME_SLOTS : fc;
      // working set either fits the table or overflows it slightly
      pool_size = ($urandom_range(0, 2) == 0) ? $urandom_range(1, active)
                                              : active + $urandom_range(1, 3);
      // refresh part of the pool; some entries sit one bit away from entry 0
      for (int k = 1; k < POOL_DEPTH; k++) begin
        roll = $urandom_range(0, 3);
        if (roll == 0) page_pool[k] = PAGE_BITS'($urandom_range(0, PAGE_MAX));
        else if (roll == 1)
          page_pool[k] = page_pool[0] ^
                         (PAGE_BITS'(1) << $urandom_range(0, PAGE_BITS - 1));
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) pg = page_pool[$urandom_range(0, pool_size - 1)];
        else if (roll < 95) pg = PAGE_BITS'($urandom_range(0, PAGE_MAX));
        else pg = $urandom_range(0, 1) ? PAGE_MAX : '0;
        if ($urandom_range(0, 199) == 0) drain_lookups();
        send_page(pg);
      end
    end

    drain_lookups();
    repeat (40) @(negedge clk);
    if (bad_results == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
